/* src/ltc_pkg.sv */
`default_nettype none
package ltc_pkg;

	// Default sizing
	localparam int MAX_TOKEN_LEN_DEF = 256;
	localparam int VALUE_WIDTH_DEF   = 64;
	localparam int FIFO_DEPTH        = 2;

	// Field widths
	localparam int KIND_W = 3;
	localparam int LEN_W  = 9;
	localparam int LEN_CAP_MAX = 511;

	// Token kinds
	localparam logic [KIND_W-1:0] KIND_HEX = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BIN = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DEC = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CHR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BUF = 3'd4;
	localparam logic [KIND_W-1:0] KIND_STR = 3'd5;

	// Character codes
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LO_X   = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_UP_B   = 8'h42;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	// Per-token descriptor handed from front to back, numeric value kept aside
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              esc;
		logic [7:0]        code;
		logic [LEN_W-1:0]  blen;
	} ltc_tag_t;

	// Hex digit: {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Escape code: {valid, decoded byte}
	function automatic logic [8:0] esc_decode(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			CH_LO_N:   r = {1'b1, 8'd10};
			CH_LO_T:   r = {1'b1, 8'd9};
			CH_LO_R:   r = {1'b1, 8'd13};
			CH_LO_B:   r = {1'b1, 8'd8};
			CH_ZERO:   r = {1'b1, 8'd0};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_SQUOTE: r = {1'b1, CH_SQUOTE};
			default:   r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/ltc_if.sv */
`default_nettype none
interface ltc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface ltc_out_if #(
	parameter int VALUE_WIDTH = ltc_pkg::VALUE_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic [ltc_pkg::KIND_W-1:0]  token_kind;
	logic [VALUE_WIDTH-1:0]      token_value;
	logic [ltc_pkg::LEN_W-1:0]   decoded_length;

	modport source (output valid, output token_kind, output token_value,
		output decoded_length, input ready);
	modport sink   (input valid, input token_kind, input token_value,
		input decoded_length, output ready);
endinterface
`default_nettype wire

/* src/ltc_front.sv */
`default_nettype none
module ltc_front #(
	parameter int MAX_TOKEN_LEN = ltc_pkg::MAX_TOKEN_LEN_DEF,
	parameter int VALUE_WIDTH   = ltc_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	ltc_in_if.sink                      chars,
	output logic                        push_valid,
	input  wire logic                   push_ready,
	output ltc_pkg::ltc_tag_t           push_tag,
	output logic [VALUE_WIDTH-1:0]      push_num
);
	import ltc_pkg::*;

	localparam int PW = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [PW-1:0] MaxLen = PW'(MAX_TOKEN_LEN);
	localparam int CapInt = (MAX_TOKEN_LEN < LEN_CAP_MAX) ? MAX_TOKEN_LEN : LEN_CAP_MAX;
	localparam logic [LEN_W-1:0] LenCap = LEN_W'(CapInt);
	localparam int VW = VALUE_WIDTH;

	logic [PW-1:0]    pos_q;
	logic             hex_ok_q, bin_ok_q, dec_ok_q, buf_ok_q, esc_q;
	logic [7:0]       e0_q, e1_q, e2_q;
	logic [VW-1:0]    hex_q, bin_q, dec_q;
	logic [LEN_W-1:0] bcnt_q;

	logic             take, last;
	logic [7:0]       c;
	logic             p0, p1, p2, is_digit;
	logic [4:0]       hd;
	logic [8:0]       ed_c, ed_e2;
	logic [PW-1:0]    pos_n, len_n;
	logic             hex_ok_n, bin_ok_n, dec_ok_n, buf_ok_n, esc_n;
	logic [7:0]       e0_n, e1_n, e2_n;
	logic [VW-1:0]    hex_n, bin_n, dec_n;
	logic [VW+3:0]    dec_wide;
	logic [LEN_W-1:0] bcnt_n;
	logic             chr_hit;

	assign take  = chars.valid && chars.ready;
	assign last  = chars.last_char;
	assign c     = chars.char_in;
	assign chars.ready = push_ready;

	assign p0 = (pos_q == PW'(0));
	assign p1 = (pos_q == PW'(1));
	assign p2 = (pos_q == PW'(2));
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign hd = hex_digit(c);
	assign ed_c = esc_decode(c);

	// Advance position, saturating at the token length limit
	assign pos_n = (pos_q == MaxLen) ? pos_q : pos_q + PW'(1);
	assign len_n = pos_n;

	// Capture the first three characters
	assign e0_n = p0 ? c : e0_q;
	assign e1_n = p1 ? c : e1_q;
	assign e2_n = p2 ? c : e2_q;
	assign ed_e2 = esc_decode(e2_n);

	// Hex candidate and accumulator
	always_comb begin
		hex_ok_n = hex_ok_q;
		hex_n    = hex_q;
		if (p0) begin
			if (c != CH_ZERO) hex_ok_n = 1'b0;
		end else if (p1) begin
			if (c != CH_LO_X && c != CH_UP_X) hex_ok_n = 1'b0;
		end else if (!hd[4]) begin
			hex_ok_n = 1'b0;
		end else if (|hex_q[VW-1:VW-4]) begin
			hex_n = '1;
		end else begin
			hex_n = {hex_q[VW-5:0], hd[3:0]};
		end
	end

	// Binary candidate and accumulator
	always_comb begin
		bin_ok_n = bin_ok_q;
		bin_n    = bin_q;
		if (p0) begin
			if (c != CH_ZERO) bin_ok_n = 1'b0;
		end else if (p1) begin
			if (c != CH_LO_B && c != CH_UP_B) bin_ok_n = 1'b0;
		end else if (c != CH_ZERO && c != CH_ONE) begin
			bin_ok_n = 1'b0;
		end else if (bin_q[VW-1]) begin
			bin_n = '1;
		end else begin
			bin_n = {bin_q[VW-2:0], c[0]};
		end
	end

	// Decimal candidate: value*10 + digit, saturate when it leaves the range
	assign dec_wide = ({4'd0, dec_q} << 3) + ({4'd0, dec_q} << 1) + (VW+4)'(c[3:0]);
	always_comb begin
		dec_ok_n = dec_ok_q && is_digit;
		dec_n    = dec_q;
		if (is_digit) begin
			dec_n = (|dec_wide[VW+3:VW]) ? '1 : dec_wide[VW-1:0];
		end
	end

	// Quoted buffer: count decoded bytes, track escapes
	always_comb begin
		buf_ok_n = buf_ok_q;
		esc_n    = esc_q;
		bcnt_n   = bcnt_q;
		if (p0) begin
			if (c != CH_DQUOTE) buf_ok_n = 1'b0;
		end else if (!last) begin
			if (esc_q) begin
				esc_n = 1'b0;
				if (!ed_c[8]) buf_ok_n = 1'b0;
				else if (bcnt_q < LenCap) bcnt_n = bcnt_q + LEN_W'(1);
			end else if (c == CH_BSLASH) begin
				esc_n = 1'b1;
			end else if (bcnt_q < LenCap) begin
				bcnt_n = bcnt_q + LEN_W'(1);
			end
		end
	end

	// Character literal shape
	assign chr_hit = (e0_n == CH_SQUOTE) && (len_n >= PW'(3)) && (c == CH_SQUOTE) &&
		(((e1_n == CH_BSLASH) && (len_n == PW'(4)) && ed_e2[8]) ||
		 ((e1_n != CH_BSLASH) && (len_n == PW'(3))));

	// Classify on the last character, by priority
	always_comb begin
		push_tag.esc  = (e1_n == CH_BSLASH);
		push_tag.code = (e1_n == CH_BSLASH) ? e2_n : e1_n;
		push_tag.blen = bcnt_q;
		push_num      = '0;
		priority if (hex_ok_n && len_n >= PW'(2)) begin
			push_tag.kind = KIND_HEX;
			push_num      = hex_n;
		end else if (bin_ok_n && len_n >= PW'(2)) begin
			push_tag.kind = KIND_BIN;
			push_num      = bin_n;
		end else if (dec_ok_n) begin
			push_tag.kind = KIND_DEC;
			push_num      = dec_n;
		end else if (chr_hit) begin
			push_tag.kind = KIND_CHR;
		end else if (buf_ok_n && len_n >= PW'(3) && c == CH_DQUOTE && !esc_q) begin
			push_tag.kind = KIND_BUF;
		end else begin
			push_tag.kind = KIND_STR;
		end
	end

	assign push_valid = chars.valid && last;

	// Hold token state; drop back to the start after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hex_ok_q <= 1'b1;
			bin_ok_q <= 1'b1;
			dec_ok_q <= 1'b1;
			buf_ok_q <= 1'b1;
			esc_q    <= 1'b0;
			e0_q     <= '0;
			e1_q     <= '0;
			e2_q     <= '0;
			hex_q    <= '0;
			bin_q    <= '0;
			dec_q    <= '0;
			bcnt_q   <= '0;
		end else if (take) begin
			if (last) begin
				pos_q    <= '0;
				hex_ok_q <= 1'b1;
				bin_ok_q <= 1'b1;
				dec_ok_q <= 1'b1;
				buf_ok_q <= 1'b1;
				esc_q    <= 1'b0;
				e0_q     <= '0;
				e1_q     <= '0;
				e2_q     <= '0;
				hex_q    <= '0;
				bin_q    <= '0;
				dec_q    <= '0;
				bcnt_q   <= '0;
			end else begin
				pos_q    <= pos_n;
				hex_ok_q <= hex_ok_n;
				bin_ok_q <= bin_ok_n;
				dec_ok_q <= dec_ok_n;
				buf_ok_q <= buf_ok_n;
				esc_q    <= esc_n;
				e0_q     <= e0_n;
				e1_q     <= e1_n;
				e2_q     <= e2_n;
				hex_q    <= hex_n;
				bin_q    <= bin_n;
				dec_q    <= dec_n;
				bcnt_q   <= bcnt_n;
			end
		end
	end

endmodule
`default_nettype wire

/* src/ltc_fifo.sv */
`default_nettype none
module ltc_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);
	import ltc_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [W-1:0]  slot_q [FIFO_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = (cnt_q != CW'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != CW'(0));
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store beat at write pointer
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop)  rd_q <= (rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

/* src/ltc_back.sv */
`default_nettype none
module ltc_back #(
	parameter int VALUE_WIDTH = ltc_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    pop_valid,
	output logic                         pop_ready,
	input  wire ltc_pkg::ltc_tag_t       pop_tag,
	input  wire logic [VALUE_WIDTH-1:0]  pop_num,
	ltc_out_if.source                    tokens
);
	import ltc_pkg::*;

	logic                   valid_q;
	logic [KIND_W-1:0]      kind_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [LEN_W-1:0]       dlen_q;
	logic [VALUE_WIDTH-1:0] value_n;
	logic [8:0]             ed;
	logic                   load;

	assign pop_ready = !valid_q || tokens.ready;
	assign load      = pop_valid && pop_ready;
	assign ed        = esc_decode(pop_tag.code);

	// Pick the result value by kind
	always_comb begin
		unique case (pop_tag.kind)
			KIND_HEX, KIND_BIN, KIND_DEC: value_n = pop_num;
			KIND_CHR: value_n = VALUE_WIDTH'(pop_tag.esc ? ed[7:0] : pop_tag.code);
			default:  value_n = '0;
		endcase
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tokens.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= pop_tag.kind;
			value_q <= value_n;
			dlen_q  <= (pop_tag.kind == KIND_BUF) ? pop_tag.blen : '0;
		end
	end

	assign tokens.valid          = valid_q;
	assign tokens.token_kind     = kind_q;
	assign tokens.token_value    = value_q;
	assign tokens.decoded_length = dlen_q;

endmodule
`default_nettype wire

/* src/literal_token_classifier_unit.sv */
`default_nettype none
// Literal token classifier. Feed one token character per beat on chars, with
// last_char set on its final character; one result beat follows on tokens
// giving the kind (hex, binary, decimal, char literal, quoted buffer, plain
// string), the value saturated to all ones, and the decoded buffer length.
// One character is taken every cycle while the queue has room; the front
// stage updates all candidate classifiers on each character, and a two-entry
// queue ahead of the output register lets the sink stall without stopping
// input until it is full. Results pass the queue, then the output register.
// The tokens interface must be built with the same VALUE_WIDTH as this unit.
module literal_token_classifier_unit #(
	parameter int MAX_TOKEN_LEN = ltc_pkg::MAX_TOKEN_LEN_DEF,
	parameter int VALUE_WIDTH   = ltc_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ltc_in_if.sink     chars,
	ltc_out_if.source  tokens
);
	import ltc_pkg::*;

	localparam int TW = $bits(ltc_tag_t);

	logic                   push_valid, push_ready, pop_valid, pop_ready;
	ltc_tag_t               push_tag, pop_tag;
	logic [VALUE_WIDTH-1:0] push_num, pop_num;
	logic [TW+VALUE_WIDTH-1:0] pop_data;

	ltc_front #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
		.VALUE_WIDTH   (VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_tag   (push_tag),
		.push_num   (push_num)
	);

	ltc_fifo #(
		.W (TW + VALUE_WIDTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_tag, push_num}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_tag = pop_data[TW+VALUE_WIDTH-1:VALUE_WIDTH];
	assign pop_num = pop_data[VALUE_WIDTH-1:0];

	ltc_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_tag   (pop_tag),
		.pop_num   (pop_num),
		.tokens    (tokens)
	);

endmodule
`default_nettype wire

/* src/ltc_checker.sv */
`default_nettype none
module ltc_checker #(
	parameter int VALUE_WIDTH = ltc_pkg::VALUE_WIDTH_DEF
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       in_last,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [ltc_pkg::KIND_W-1:0] out_kind,
	input wire logic [VALUE_WIDTH-1:0]     out_value,
	input wire logic [ltc_pkg::LEN_W-1:0]  out_dlen
);
	import ltc_pkg::*;

	logic [2:0] pend_q;
	logic       tok_in, tok_out;

	assign tok_in  = in_valid && in_ready && in_last;
	assign tok_out = out_valid && out_ready;

	// Count tokens closed on input but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (tok_in && !tok_out) begin
			pend_q <= pend_q + 3'd1;
		end else if (tok_out && !tok_in) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 3'd0))
		else $error("result beat without a closed token");

	a_len_only_buf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind != KIND_BUF) |-> (out_dlen == '0))
		else $error("decoded length set on a non-buffer kind");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind == KIND_BUF || out_kind == KIND_STR)) |-> (out_value == '0))
		else $error("value set on buffer or plain string");

	a_chr_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == KIND_CHR) |-> (out_value < VALUE_WIDTH'(256)))
		else $error("char literal value wider than a byte");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_value)))
		else $error("stalled result beat changed");

endmodule

bind literal_token_classifier_unit ltc_checker #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_ltc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last_char),
	.out_valid (tokens.valid),
	.out_ready (tokens.ready),
	.out_kind  (tokens.token_kind),
	.out_value (tokens.token_value),
	.out_dlen  (tokens.decoded_length)
);
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ltc_pkg::*;

	localparam int VAL_W = VALUE_WIDTH_DEF;
	localparam int MAX_LEN = MAX_TOKEN_LEN_DEF;
	localparam int LEN_CAP = (MAX_TOKEN_LEN_DEF < LEN_CAP_MAX) ? MAX_TOKEN_LEN_DEF : LEN_CAP_MAX;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	// Candidate bits of the token being scanned
	localparam int CAND_HEX = 0;
	localparam int CAND_BIN = 1;
	localparam int CAND_DEC = 2;
	localparam int CAND_CHR = 3;
	localparam int CAND_BUF = 4;

	localparam int IDLE_PCT = 14;
	localparam int CALM_FROM = 150;
	localparam int CALM_TO = 350;
	localparam int HOLD_AT = 680;
	localparam int HOLD_LEN = 120;
	localparam int RANDOM_CHARS = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;

	typedef logic [7:0] text_t[$];

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VAL_W-1:0]  value;
		logic [LEN_W-1:0]  dlen;
	} token_result_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ltc_in_if chars ();
	ltc_out_if #(.VALUE_WIDTH(VAL_W)) tokens ();

	literal_token_classifier_unit #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN_DEF),
		.VALUE_WIDTH(VAL_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.tokens(tokens)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	char_beat_t text_beats[$];
	token_result_t expected_tokens[$];
	int chars_beats = 0;
	logic chars_fired = 1'b0;
	int fail_count = 0;
	int hold_left = 0;
	bit hold_used = 1'b0;
	logic calm;

	assign calm = chars_beats >= CALM_FROM && chars_beats < CALM_TO;

	// Scanner state for the token in flight
	int unsigned tok_pos = 0;
	logic [4:0] cand = '1;
	bit esc_pend = 1'b0;
	logic [7:0] early [3] = '{default: '0};
	logic [VAL_W-1:0] hex_acc = '0;
	logic [VAL_W-1:0] bin_acc = '0;
	logic [VAL_W-1:0] dec_acc = '0;
	int buf_cnt = 0;
	bit buf_ok = 1'b1;

	// Decoded byte of an escape code, -1 when the code is unknown
	function automatic int esc_byte(input logic [7:0] c);
		case (c)
			CH_LO_N:   return 10;
			CH_LO_T:   return 9;
			CH_LO_R:   return 13;
			CH_LO_B:   return 8;
			CH_ZERO:   return 0;
			CH_BSLASH: return 92;
			CH_SQUOTE: return 39;
			default:   return -1;
		endcase
	endfunction

	function automatic int hex_val(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
		if (c >= CH_LO_A && c <= CH_LO_F) return c - CH_LO_A + 10;
		if (c >= CH_UP_A && c <= CH_UP_F) return c - CH_UP_A + 10;
		return -1;
	endfunction

	// Advance the scanner by one character; return 1 with the token result on the last one
	function automatic bit scan_char(input logic [7:0] c, input logic last,
		output token_result_t r);
		int unsigned p;
		int unsigned len;
		int hd;
		logic [VAL_W-1:0] digit;
		logic [7:0] e0, e1, e2;
		p = tok_pos;
		hd = hex_val(c);
		r = '0;
		if (p < 3) early[p] = c;

		// hex: 0x prefix then hex digits
		if (p == 0) begin
			if (c != CH_ZERO) cand[CAND_HEX] = 1'b0;
		end else if (p == 1) begin
			if (c != CH_LO_X && c != CH_UP_X) cand[CAND_HEX] = 1'b0;
		end else if (hd < 0) begin
			cand[CAND_HEX] = 1'b0;
		end else if (hex_acc > (VAL_MAX >> 4)) begin
			hex_acc = VAL_MAX;
		end else begin
			digit = VAL_W'(hd);
			hex_acc = (hex_acc << 4) | digit;
		end

		// binary: 0b prefix then bits
		if (p == 0) begin
			if (c != CH_ZERO) cand[CAND_BIN] = 1'b0;
		end else if (p == 1) begin
			if (c != CH_LO_B && c != CH_UP_B) cand[CAND_BIN] = 1'b0;
		end else if (c != CH_ZERO && c != CH_ONE) begin
			cand[CAND_BIN] = 1'b0;
		end else if (bin_acc > (VAL_MAX >> 1)) begin
			bin_acc = VAL_MAX;
		end else begin
			bin_acc = (bin_acc << 1) | VAL_W'(c == CH_ONE);
		end

		// decimal: digits only
		if (c < CH_ZERO || c > CH_NINE) begin
			cand[CAND_DEC] = 1'b0;
		end else begin
			digit = VAL_W'(c - CH_ZERO);
			if (dec_acc > (VAL_MAX - digit) / 10) dec_acc = VAL_MAX;
			else dec_acc = dec_acc * 10 + digit;
		end

		// quoted buffer: count decoded bytes, the closing character excluded
		if (p == 0) begin
			if (c != CH_DQUOTE) cand[CAND_BUF] = 1'b0;
		end else if (!last) begin
			if (esc_pend) begin
				esc_pend = 1'b0;
				if (esc_byte(c) < 0) buf_ok = 1'b0;
				else if (buf_cnt < LEN_CAP) buf_cnt++;
			end else if (c == CH_BSLASH) begin
				esc_pend = 1'b1;
			end else if (buf_cnt < LEN_CAP) begin
				buf_cnt++;
			end
		end

		if (tok_pos < MAX_LEN) tok_pos++;
		if (!last) return 1'b0;

		// classify by priority
		len = tok_pos;
		e0 = early[0];
		e1 = early[1];
		e2 = early[2];
		r.kind = KIND_STR;
		if (cand[CAND_HEX] && len >= 2) begin
			r.kind = KIND_HEX;
			r.value = hex_acc;
		end else if (cand[CAND_BIN] && len >= 2) begin
			r.kind = KIND_BIN;
			r.value = bin_acc;
		end else if (cand[CAND_DEC]) begin
			r.kind = KIND_DEC;
			r.value = dec_acc;
		end else if (e0 == CH_SQUOTE && len >= 3 && c == CH_SQUOTE &&
			((e1 == CH_BSLASH && len == 4 && esc_byte(e2) >= 0) ||
			(e1 != CH_BSLASH && len == 3))) begin
			r.kind = KIND_CHR;
			if (e1 == CH_BSLASH) r.value = VAL_W'(esc_byte(e2));
			else r.value = VAL_W'(e1);
		end else if (cand[CAND_BUF] && len >= 3 && c == CH_DQUOTE && !esc_pend && buf_ok) begin
			r.kind = KIND_BUF;
			r.dlen = LEN_W'(buf_cnt);
		end

		// back to the idle scanner state
		tok_pos = 0;
		cand = '1;
		esc_pend = 1'b0;
		early = '{default: '0};
		hex_acc = '0;
		bin_acc = '0;
		dec_acc = '0;
		buf_cnt = 0;
		buf_ok = 1'b1;
		return 1'b1;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	// Mostly printable, sometimes any nonzero byte
	function automatic logic [7:0] rand_text_char();
		if ($urandom_range(99) < 85) return 8'($urandom_range(8'h20, 8'h7E));
		return rand_byte();
	endfunction

	// Mostly a known escape code, sometimes any nonzero byte
	function automatic logic [7:0] rand_escape();
		string codes;
		codes = "ntrb0\\'";
		if ($urandom_range(9) == 0) return rand_byte();
		return codes[$urandom_range(codes.len() - 1)];
	endfunction

	// Short bodies, now and then one past the length cap
	function automatic int rand_len();
		if ($urandom_range(59) == 0) return $urandom_range(257, 300);
		return $urandom_range(12);
	endfunction

	function automatic text_t text_of(input string s);
		text_t t;
		for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
		return t;
	endfunction

	// Well-formed token of the given kind with random content
	function automatic text_t make_token(input logic [KIND_W-1:0] kind);
		text_t t;
		string hex_chars;
		int n;
		hex_chars = "0123456789abcdefABCDEF";
		case (kind)
			KIND_HEX: begin
				t = {CH_ZERO, $urandom_range(1) ? CH_LO_X : CH_UP_X};
				n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(16);
				repeat (n) t.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
			end
			KIND_BIN: begin
				t = {CH_ZERO, $urandom_range(1) ? CH_LO_B : CH_UP_B};
				n = ($urandom_range(9) == 0) ? $urandom_range(64, 68) : $urandom_range(20);
				repeat (n) t.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
			end
			KIND_DEC: begin
				n = ($urandom_range(9) == 0) ? $urandom_range(19, 22) : $urandom_range(1, 12);
				repeat (n) t.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
			end
			KIND_CHR: begin
				t.push_back(CH_SQUOTE);
				if ($urandom_range(2) == 0) begin
					t.push_back(CH_BSLASH);
					t.push_back(rand_escape());
				end else begin
					t.push_back(rand_byte());
				end
				t.push_back(CH_SQUOTE);
			end
			KIND_BUF: begin
				t.push_back(CH_DQUOTE);
				n = rand_len();
				repeat (n) begin
					if ($urandom_range(4) == 0) begin
						t.push_back(CH_BSLASH);
						t.push_back(rand_escape());
					end else begin
						t.push_back(rand_text_char());
					end
				end
				if ($urandom_range(11) == 0) t.push_back(CH_BSLASH);
				t.push_back(CH_DQUOTE);
			end
			default: begin
				n = rand_len() + 1;
				repeat (n) t.push_back($urandom_range(1) ? rand_text_char() : rand_byte());
			end
		endcase
		return t;
	endfunction

	// Random token; a fifth of them get one byte broken, dropped or added
	function automatic text_t rand_token();
		text_t t;
		int idx;
		t = make_token(KIND_W'($urandom_range(KIND_STR)));
		if ($urandom_range(4) == 0) begin
			idx = $urandom_range(t.size() - 1);
			case ($urandom_range(2))
				0: t[idx] = rand_byte();
				1: if (t.size() > 1) void'(t.pop_back());
				default: t.insert(idx, rand_byte());
			endcase
		end
		return t;
	endfunction

	task automatic queue_text(input text_t t);
		char_beat_t b;
		foreach (t[i]) begin
			b.ch = t[i];
			b.last = (i == t.size() - 1);
			text_beats.push_back(b);
		end
	endtask

	task automatic note_failure(input string msg);
		if (fail_count < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Offer the next character, hold it until taken
	always @(negedge clk) begin : char_driver
		char_beat_t b;
		if (!arst_n) begin
			chars.valid <= 1'b0;
		end else if (!chars.valid || chars_fired) begin
			if (text_beats.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				b = text_beats.pop_front();
				chars.valid <= 1'b1;
				chars.char_in <= b.ch;
				chars.last_char <= b.last;
			end else begin
				chars.valid <= 1'b0;
			end
		end
	end

	// Count down the long receiver hold-off once the run is under way
	always @(negedge clk) begin : sink_hold_ctl
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && chars_beats >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_used <= 1'b1;
		end
	end

	// Stall the result side at random, or for the whole hold-off
	always @(negedge clk) begin : sink_pacer
		tokens.ready <= arst_n && hold_left == 0 && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	// Predict on each character beat, check each result beat
	always @(posedge clk) begin : token_checker
		token_result_t got, want;
		if (!arst_n) begin
			chars_fired <= 1'b0;
		end else begin
			chars_fired <= chars.valid && chars.ready;
			if (chars.valid && chars.ready) begin
				chars_beats <= chars_beats + 1;
				if (scan_char(chars.char_in, chars.last_char, want)) expected_tokens.push_back(want);
			end
			if (tokens.valid && tokens.ready) begin
				got.kind = tokens.token_kind;
				got.value = tokens.token_value;
				got.dlen = tokens.decoded_length;
				if (expected_tokens.size() == 0) begin
					note_failure($sformatf("unexpected result kind %0d value %h length %0d",
						got.kind, got.value, got.dlen));
				end else begin
					want = expected_tokens.pop_front();
					if (got.kind !== want.kind || got.value !== want.value ||
						got.dlen !== want.dlen) begin
						note_failure($sformatf(
							"mismatch kind %0d/%0d value %h/%h length %0d/%0d (exp/act)",
							want.kind, got.kind, want.value, got.value, want.dlen, got.dlen));
					end
				end
			end
		end
	end

	initial begin : stimulus
		text_t t;
		int random_chars;
		chars.valid = 1'b0;
		chars.char_in = '0;
		chars.last_char = 1'b0;
		tokens.ready = 1'b0;
		random_chars = 0;

		// bare prefixes, single zero, hex extremes and overflow
		queue_text(text_of("0x"));
		queue_text(text_of("0B"));
		queue_text(text_of("0"));
		queue_text(text_of("0xdeadBEEF09"));
		queue_text(text_of("0XFFFFFFFFFFFFFFFF"));
		queue_text(text_of("0x10000000000000000"));
		queue_text(text_of("0xg1"));

		// binary at full width and one bit over
		t = {CH_ZERO, CH_LO_B};
		repeat (64) t.push_back(CH_ONE);
		queue_text(t);
		t = {CH_ZERO, CH_UP_B, CH_ONE};
		repeat (64) t.push_back(CH_ZERO);
		queue_text(t);

		// decimal at the top and just past it
		queue_text(text_of("18446744073709551615"));
		queue_text(text_of("18446744073709551616"));
		queue_text(text_of("0123456789"));

		// character literals: plain, every escape, unknown escape, too long
		queue_text(text_of("'A'"));
		queue_text(text_of("'\\n'"));
		queue_text(text_of("'\\t'"));
		queue_text(text_of("'\\r'"));
		queue_text(text_of("'\\b'"));
		queue_text(text_of("'\\0'"));
		queue_text(text_of("'\\\\'"));
		queue_text(text_of("'\\''"));
		queue_text(text_of("'\\q'"));
		queue_text(text_of("'ab'"));

		// buffers: good, escape before close, unknown escape, too short
		queue_text(text_of("\"ab\\tc\""));
		queue_text(text_of("\"ab\\\""));
		queue_text(text_of("\"x\\zy\""));
		queue_text(text_of("\"\""));

		// single lowest and highest bytes
		queue_text('{8'h01});
		queue_text('{8'hFF});

		// long buffer past the length cap
		t = {CH_DQUOTE};
		repeat (298) t.push_back(8'($urandom_range(CH_UP_A, 8'h5A)));
		t.push_back(CH_DQUOTE);
		queue_text(t);

		while (random_chars < RANDOM_CHARS) begin
			t = rand_token();
			random_chars += t.size();
			queue_text(t);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (text_beats.size() != 0 || chars.valid) @(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_tokens.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
